// ----- rtl/tccs_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the text console.
// No dependencies; used by tccs_ctrl, tccs_dp and the top level (tccs_ram does not use it).
package tccs_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int POS_W = 11;
  localparam int SCR_W = 5;
  localparam int XW = 18;
  localparam int M_W = 16;
  localparam int DIV_K = 24;
  localparam int RECIP = (2 ** DIV_K + COLS - 1) / COLS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int Q_W = $clog2((2 ** M_W) / COLS + 1);
  localparam logic [7:0] NEWLINE = 8'd10;

  typedef enum logic [2:0] {
    K_PUT_CURSOR  = 3'd0,
    K_PUT_PLACE   = 3'd1,
    K_SET_CURSOR  = 3'd2,
    K_MOVE_CURSOR = 3'd3,
    K_CLEAR       = 3'd4,
    K_READ        = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PLACE,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic divide;
    logic place;
    logic capture;
    logic sweep_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  sweep_needed;
    logic  sweep_done;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/tccs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tccs_ctrl.sv -----
// Controller state machine of the text console: sequences division, placement,
// screen sweeps and result hand-off. Depends on tccs_pkg.
module tccs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  tccs_pkg::sts_t sts,
  output tccs_pkg::cmd_t cmd
);
  import tccs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.sweep_done) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_DIV;
      ST_DIV:   state_next = ST_PLACE;
      ST_PLACE: begin
        if (sts.sweep_needed) state_next = ST_SWEEP;
        else if (sts.kind == K_READ) state_next = ST_READ;
        else state_next = ST_DONE;
      end
      ST_SWEEP: if (sts.sweep_done) state_next = ST_DONE;
      ST_READ:  state_next = ST_DONE;
      ST_DONE:  if (sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.sweep_step = 1'b1;
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIV:   cmd.divide = 1'b1;
      ST_PLACE: cmd.place = 1'b1;
      ST_SWEEP: cmd.sweep_step = 1'b1;
      ST_READ:  cmd.capture = 1'b1;
      ST_DONE:  cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |-> ($past(state) == ST_DIV))
    else $error("Placement not preceded by division.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_DIV))
    else $error("Accepted item did not start division.");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.divide, cmd.place, cmd.capture, cmd.sweep_step, cmd.out_load}))
    else $error("More than one datapath command at once.");

endmodule

// ----- rtl/tccs_dp.sv -----
// Datapath of the text console: operand capture, divide by the column count,
// cell placement, cursor and scroll logic, screen memory sweeps and the result register.
// Depends on tccs_pkg and tccs_ram.
module tccs_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic [47:0]    s_tdata,
  input  logic [2:0]     s_tuser,
  input  tccs_pkg::cmd_t cmd,
  output tccs_pkg::sts_t sts,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata
);
  import tccs_pkg::*;

  localparam logic signed [XW-1:0] ROW_LAST = XW'(ROWS - 1);
  localparam logic signed [XW-1:0] ROW_TOP = XW'(2 * ROWS);
  localparam logic signed [XW-1:0] ROW_CNT = XW'(ROWS);

  kind_t                   kind_r;
  logic [7:0]              ch_r;
  logic [7:0]              attr_r;
  logic signed [XW-1:0]    x_r, y_r;
  logic [M_W-1:0]          m_r;
  logic                    neg_r;
  logic [Q_W-1:0]          q_r;
  logic [COL_W-1:0]        cur_col;
  logic [ROW_W-1:0]        cur_row;
  logic [SCR_W-1:0]        scroll_r;
  logic [CNT_W-1:0]        keep_r, off_r, cnt;
  logic [15:0]             rd_cell;

  kind_t                   in_kind;
  logic signed [XW-1:0]    in_col, in_row, cur_col_x, cur_row_x, x_in, y_in;
  logic signed [XW-1:0]    m_abs_x;
  logic [M_W+RECIP_W-1:0]  prod;
  logic [M_W:0]            r_full;
  logic [COL_W-1:0]        r;
  logic signed [XW-1:0]    q_x, yy, po_y, cy, cy_top;
  logic [COL_W-1:0]        po_x, cx;
  logic [ROW_W-1:0]        c_row;
  logic [SCR_W-1:0]        c_scroll;
  logic [CELL_AW-1:0]      pos_of, cur_addr;
  logic                    cursor_kind, put_char;

  logic                    we;
  logic [CELL_AW-1:0]      waddr, raddr;
  logic [15:0]             wdata, rdata;
  logic [CNT_W-1:0]        cnt_prev, src;

  assign in_kind   = kind_t'(s_tuser);
  assign in_col    = {{(XW-16){s_tdata[31]}}, s_tdata[31:16]};
  assign in_row    = {{(XW-16){s_tdata[47]}}, s_tdata[47:32]};
  assign cur_col_x = {{(XW-COL_W){1'b0}}, cur_col};
  assign cur_row_x = {{(XW-ROW_W){1'b0}}, cur_row};

  always_comb begin
    x_in = in_col;
    y_in = in_row;
    unique case (in_kind)
      K_PUT_CURSOR: begin
        if (s_tdata[7:0] == NEWLINE) begin
          x_in = '0;
          y_in = cur_row_x + XW'(1);
        end else begin
          x_in = cur_col_x + XW'(1);
          y_in = cur_row_x;
        end
      end
      K_MOVE_CURSOR: begin
        x_in = cur_col_x + in_col;
        y_in = cur_row_x + in_row;
      end
      default: ;
    endcase
  end

  assign m_abs_x = x_r[XW-1] ? -x_r : x_r;
  assign prod    = m_abs_x[M_W-1:0] * RECIP_W'(RECIP);
  assign r_full  = {1'b0, m_r} - (M_W+1)'(q_r * COLS);
  assign r       = r_full[COL_W-1:0];
  assign q_x     = {{(XW-Q_W){1'b0}}, q_r};

  // Cell placement for writes and reads at a given place.
  always_comb begin
    yy   = y_r - q_x - XW'(1);
    po_x = '0;
    po_y = '0;
    if (neg_r) begin
      if (!yy[XW-1]) begin
        if (r == '0) begin
          po_y = yy + XW'(1);
        end else begin
          po_x = COL_W'(COLS) - r;
          po_y = yy;
        end
      end
    end else if (!y_r[XW-1]) begin
      po_x = r;
      po_y = y_r + q_x;
    end
    if (po_y > ROW_LAST) po_y = ROW_LAST;
    pos_of = CELL_AW'(po_y[ROW_W-1:0] * COLS) + CELL_AW'(po_x);
  end

  // Cursor placement with scrolling past the bottom row.
  always_comb begin
    if (neg_r) begin
      if (r == '0) begin
        cx = '0;
        cy = y_r - q_x;
      end else begin
        cx = COL_W'(COLS) - r;
        cy = y_r - q_x - XW'(1);
      end
    end else begin
      cx = r;
      cy = y_r + q_x;
    end
    if (cy[XW-1]) cy = '0;
    cy_top = (cy > ROW_TOP) ? ROW_TOP : cy;
    if (cy >= ROW_CNT) begin
      c_scroll = SCR_W'(cy_top - ROW_LAST);
      c_row    = ROW_W'(ROWS - 1);
    end else begin
      c_scroll = '0;
      c_row    = cy[ROW_W-1:0];
    end
  end

  assign cursor_kind = (kind_r == K_PUT_CURSOR) || (kind_r == K_SET_CURSOR) ||
                       (kind_r == K_MOVE_CURSOR);
  assign put_char    = (kind_r == K_PUT_CURSOR) && (ch_r != NEWLINE);
  assign cur_addr    = CELL_AW'(cur_row * COLS) + CELL_AW'(cur_col);

  assign sts.kind         = kind_r;
  assign sts.sweep_needed = (kind_r == K_CLEAR) || (cursor_kind && (c_scroll != '0));
  assign sts.sweep_done   = (cnt == CNT_W'(CELLS));
  assign sts.out_free     = !m_tvalid || m_tready;

  assign cnt_prev = cnt - CNT_W'(1);
  assign src      = cnt + off_r;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_prev[CELL_AW-1:0];
    wdata = '0;
    raddr = pos_of;
    if (cmd.sweep_step) begin
      raddr = (cnt < keep_r) ? src[CELL_AW-1:0] : '0;
      we    = (cnt != '0);
      wdata = (cnt_prev < keep_r) ? rdata : '0;
    end else if (cmd.place) begin
      wdata = {attr_r, ch_r};
      if (kind_r == K_PUT_PLACE) begin
        we    = 1'b1;
        waddr = pos_of;
      end else if (put_char) begin
        we    = 1'b1;
        waddr = cur_addr;
      end
    end
  end

  tccs_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      ch_r   <= s_tdata[7:0];
      attr_r <= s_tdata[15:8];
      x_r    <= x_in;
      y_r    <= y_in;
    end
    if (cmd.divide) begin
      neg_r <= x_r[XW-1];
      m_r   <= m_abs_x[M_W-1:0];
      q_r   <= prod[DIV_K +: Q_W];
    end
    if (cmd.capture) begin
      rd_cell <= rdata;
    end
    if (cmd.out_load) begin
      m_tdata <= {scroll_r,
                  (kind_r == K_READ) ? rd_cell : 16'h0000,
                  POS_W'(cur_row * COLS) + POS_W'(cur_col)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_row  <= '0;
      scroll_r <= '0;
      keep_r   <= '0;
      off_r    <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.place) begin
        cnt      <= '0;
        scroll_r <= '0;
        if (cursor_kind) begin
          cur_col  <= cx;
          cur_row  <= c_row;
          scroll_r <= c_scroll;
          keep_r   <= (c_scroll >= SCR_W'(ROWS)) ? '0 :
                      CNT_W'((SCR_W'(ROWS) - c_scroll) * COLS);
          off_r    <= CNT_W'(c_scroll * COLS);
        end else if (kind_r == K_CLEAR) begin
          cur_col <= '0;
          cur_row <= '0;
          keep_r  <= '0;
        end
      end else if (cmd.sweep_step && !sts.sweep_done) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(COLS)) && (cur_row < ROW_W'(ROWS)))
    else $error("Cursor outside the screen.");

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CELLS))
    else $error("Sweep counter ran past the screen.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (m_tdata[31:27] <= SCR_W'(ROWS + 1)))
    else $error("Scroll count beyond its limit.");

endmodule

// ----- rtl/text_console_cursor_scroll.sv -----
// Top level of the character-cell text console with cursor and scrolling.
// Depends on tccs_pkg, tccs_ctrl, tccs_dp and tccs_ram.
//
// Usage: one command item enters on the s_ channel and one result item leaves on the
// m_ channel for every command. The input kind travels in s_tuser; s_tdata carries the
// character, attribute, signed column and signed row. The result carries the cursor
// position, the cell read by a read command (zero otherwise) and the rows scrolled.
// A new command is accepted only in the idle state, once the previous item has handed its
// result to the result register. A clear, or a cursor update that scrolls, sweeps the
// whole 2000-cell screen memory through its single write port. After reset the block
// blanks the screen with s_tready low. The result register holds a finished item while
// the receiver stalls, and the next command is accepted meanwhile; its result waits
// until the register frees.
module text_console_cursor_scroll (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // character[7:0], attribute[15:8], column[31:16], row[47:32]
  input  logic [2:0]  s_tuser,  // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // cursor_position[10:0], read_character[18:11],
                                // read_attribute[26:19], rows_scrolled[31:27]
);
  import tccs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tccs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
